### hw/rtl/udq_pkg.sv
// Shared widths, codes and types of the uniform domain quantizer.
package udq_pkg;

    localparam int VAL_W   = 32;
    localparam int STEP_W  = 31;
    localparam int IDX_W   = 16;
    localparam int OP_W    = 3;
    localparam int MODE_W  = 2;

    // divider operand widths: numerator holds 2*diff + step - 1
    localparam int NUM_W   = VAL_W + 2;
    localparam int DEN_W   = STEP_W + 1;
    localparam int QUO_W   = IDX_W + 1;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int S_DATA_W = ((VAL_W + MODE_W + 1 + IDX_W + 7) / 8) * 8;
    localparam int S_USER_W = OP_W + 1;
    localparam int M_DATA_W = ((VAL_W + IDX_W + 7) / 8) * 8;
    localparam int M_USER_W = 1;

    localparam logic [OP_W-1:0] OP_INDEX    = 3'd0;
    localparam logic [OP_W-1:0] OP_SNAP     = 3'd1;
    localparam logic [OP_W-1:0] OP_NEXT_LO  = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT_HI  = 3'd3;
    localparam logic [OP_W-1:0] OP_EQ_LO    = 3'd4;
    localparam logic [OP_W-1:0] OP_EQ_HI    = 3'd5;
    localparam logic [OP_W-1:0] OP_AT_INDEX = 3'd6;

    localparam logic [MODE_W-1:0] MODE_FLOOR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CEIL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD   = 2'd3;

    localparam logic [2:0] REG_D0_LOW  = 3'd0;
    localparam logic [2:0] REG_D0_HIGH = 3'd1;
    localparam logic [2:0] REG_D0_STEP = 3'd2;
    localparam logic [2:0] REG_D0_PTS  = 3'd3;
    localparam logic [2:0] REG_D1_LOW  = 3'd4;
    localparam logic [2:0] REG_D1_HIGH = 3'd5;
    localparam logic [2:0] REG_D1_STEP = 3'd6;
    localparam logic [2:0] REG_D1_PTS  = 3'd7;

    typedef struct packed {
        logic signed [VAL_W-1:0] low;
        logic signed [VAL_W-1:0] high;
        logic [STEP_W-1:0]       step;
        logic [IDX_W-1:0]        points;
    } dom_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic                    dsel;
        logic signed [VAL_W-1:0] val;
        logic                    wrap;
        logic [IDX_W-1:0]        sidx;
        logic                    lo;
        logic                    hi;
        logic                    zstep;
        logic                    err;
    } ctl_t;

endpackage

### hw/rtl/udq_divider.sv
// Pipelined radix-2 restoring divider with saturating quotient and sideband.
module udq_divider
    import udq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  ctl_t             in_ctl,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [QUO_W-1:0] out_quo,
    output ctl_t             out_ctl
);

    localparam int NST = QUO_W + 1;
    localparam int CW  = DEN_W + QUO_W;

    logic             v_reg   [NST];
    logic             en      [NST];
    logic [NUM_W-1:0] rem_reg [NST];
    logic [DEN_W-1:0] den_reg [NST];
    logic [QUO_W-1:0] quo_reg [NST];
    logic             ovf_reg [NST];
    ctl_t             ctl_reg [NST];

    genvar s;
    for (s = 0; s < NST; s++)
    begin : g_st
        if (s == NST - 1)
        begin : g_tail
            assign en[s] = ~v_reg[s] | out_ready;
        end
        else
        begin : g_mid
            assign en[s] = ~v_reg[s] | en[s+1];
        end

        if (s == 0)
        begin : g_head
            logic ovf_next;
            // quotient at or above 2^QUO_W saturates
            assign ovf_next = CW'(in_num) >= (CW'(in_den) << QUO_W);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else if (en[s])
                    v_reg[s] <= in_valid;
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= in_num;
                    den_reg[s] <= in_den;
                    quo_reg[s] <= '0;
                    ovf_reg[s] <= ovf_next;
                    ctl_reg[s] <= in_ctl;
                end
            end
        end
        else
        begin : g_bit
            localparam int B = NST - 1 - s;
            logic [CW-1:0]    sh;
            logic [CW-1:0]    diff_w;
            logic             ge;
            logic [QUO_W-1:0] quo_next;
            logic [NUM_W-1:0] rem_next;

            assign sh     = CW'(den_reg[s-1]) << B;
            assign ge     = CW'(rem_reg[s-1]) >= sh;
            assign diff_w = CW'(rem_reg[s-1]) - sh;

            always_comb
            begin
                quo_next    = quo_reg[s-1];
                quo_next[B] = ge;
                rem_next    = ge ? diff_w[NUM_W-1:0] : rem_reg[s-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else if (en[s])
                    v_reg[s] <= v_reg[s-1];
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_reg[s-1];
                    quo_reg[s] <= quo_next;
                    ovf_reg[s] <= ovf_reg[s-1];
                    ctl_reg[s] <= ctl_reg[s-1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];
    assign out_quo   = ovf_reg[NST-1] ? {QUO_W{1'b1}} : quo_reg[NST-1];
    assign out_ctl   = ctl_reg[NST-1];

endmodule

### hw/rtl/uniform_domain_quantizer.sv
// Throughput: one beat per cycle unless the output stalls; 2 input/prep stages,
// 18 divider stages (one per quotient bit plus a saturation check), then clamp,
// multiply, offset add, neighbor/saturate and output.
// Each stage advances when it is empty or the next one moves, so bubbles collapse under backpressure.
// Reset: rst_n clears all valid bits and the eight domain registers to zero at once.
// Top level of the uniform domain quantizer.
module uniform_domain_quantizer
    import udq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // value[31:0], snap_mode[33:32], wrap[34], step_index[50:35], zero fill
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // operation[2:0], domain_select[3]
    input  logic [S_USER_W-1:0] s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // result_value[31:0], result_index[47:32]
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // status[0]
    output logic [M_USER_W-1:0] m_axis_tuser
);

    localparam int MW = STEP_W + IDX_W;
    localparam int SW = MW + 2;
    localparam logic signed [SW-1:0] VMAX = {{(SW-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN = ~VMAX;

    typedef struct packed {
        ctl_t             ctl;
        logic [IDX_W-1:0] k;
        logic             first;
        logic             last;
    } post_t;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SW-1:0] x);
        logic signed [VAL_W-1:0] r;
        if (x > VMAX)
            r = VMAX[VAL_W-1:0];
        else if (x < VMIN)
            r = VMIN[VAL_W-1:0];
        else
            r = x[VAL_W-1:0];
        return r;
    endfunction

    // ---------------- configuration ----------------
    dom_t       dom0_reg;
    dom_t       dom1_reg;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dom0_reg <= '0;
            dom1_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_D0_LOW:  dom0_reg.low    <= pwdata[VAL_W-1:0];
                REG_D0_HIGH: dom0_reg.high   <= pwdata[VAL_W-1:0];
                REG_D0_STEP: dom0_reg.step   <= pwdata[STEP_W-1:0];
                REG_D0_PTS:  dom0_reg.points <= pwdata[IDX_W-1:0];
                REG_D1_LOW:  dom1_reg.low    <= pwdata[VAL_W-1:0];
                REG_D1_HIGH: dom1_reg.high   <= pwdata[VAL_W-1:0];
                REG_D1_STEP: dom1_reg.step   <= pwdata[STEP_W-1:0];
                REG_D1_PTS:  dom1_reg.points <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_D0_LOW:  prdata = DATA_W'(unsigned'(dom0_reg.low));
            REG_D0_HIGH: prdata = DATA_W'(unsigned'(dom0_reg.high));
            REG_D0_STEP: prdata = DATA_W'(dom0_reg.step);
            REG_D0_PTS:  prdata = DATA_W'(dom0_reg.points);
            REG_D1_LOW:  prdata = DATA_W'(unsigned'(dom1_reg.low));
            REG_D1_HIGH: prdata = DATA_W'(unsigned'(dom1_reg.high));
            REG_D1_STEP: prdata = DATA_W'(dom1_reg.step);
            REG_D1_PTS:  prdata = DATA_W'(dom1_reg.points);
            default:     prdata = '0;
        endcase
    end

    // ---------------- stage enables ----------------
    logic en_a, en_b, en_c, en_d, en_e, en_f, en_g;
    logic div_in_ready;
    logic div_v;
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, g_v_reg;

    assign en_g = ~g_v_reg | m_axis_tready;
    assign en_f = ~f_v_reg | en_g;
    assign en_e = ~e_v_reg | en_f;
    assign en_d = ~d_v_reg | en_e;
    assign en_c = ~c_v_reg | en_d;
    assign en_b = ~b_v_reg | div_in_ready;
    assign en_a = ~a_v_reg | en_b;

    assign s_axis_tready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_v_reg <= s_axis_tvalid;
            if (en_b)
                b_v_reg <= a_v_reg;
            if (en_c)
                c_v_reg <= div_v;
            if (en_d)
                d_v_reg <= c_v_reg;
            if (en_e)
                e_v_reg <= d_v_reg;
            if (en_f)
                f_v_reg <= e_v_reg;
            if (en_g)
                g_v_reg <= f_v_reg;
        end
    end

    // ---------------- A: input register ----------------
    logic [OP_W-1:0]         a_op_reg;
    logic                    a_dsel_reg;
    logic signed [VAL_W-1:0] a_val_reg;
    logic [MODE_W-1:0]       a_mode_reg;
    logic                    a_wrap_reg;
    logic [IDX_W-1:0]        a_sidx_reg;

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_val_reg  <= s_axis_tdata[VAL_W-1:0];
            a_mode_reg <= s_axis_tdata[VAL_W +: MODE_W];
            a_wrap_reg <= s_axis_tdata[VAL_W+MODE_W];
            a_sidx_reg <= s_axis_tdata[VAL_W+MODE_W+1 +: IDX_W];
            a_op_reg   <= s_axis_tuser[OP_W-1:0];
            a_dsel_reg <= s_axis_tuser[OP_W];
        end
    end

    // ---------------- B: bounds, error, offset ----------------
    dom_t                dom_a;
    ctl_t                b_ctl_next;
    logic signed [VAL_W:0] diff_w;
    ctl_t                b_ctl_reg;
    logic [MODE_W-1:0]   b_mode_reg;
    logic [VAL_W-1:0]    b_diff_reg;

    assign dom_a  = a_dsel_reg ? dom1_reg : dom0_reg;
    assign diff_w = {a_val_reg[VAL_W-1], a_val_reg} - {dom_a.low[VAL_W-1], dom_a.low};

    always_comb
    begin
        b_ctl_next.op    = a_op_reg;
        b_ctl_next.dsel  = a_dsel_reg;
        b_ctl_next.val   = a_val_reg;
        b_ctl_next.wrap  = a_wrap_reg;
        b_ctl_next.sidx  = a_sidx_reg;
        b_ctl_next.lo    = a_val_reg <= dom_a.low;
        b_ctl_next.hi    = a_val_reg >= dom_a.high;
        b_ctl_next.zstep = dom_a.step == '0;
        if (a_op_reg == OP_AT_INDEX)
            b_ctl_next.err = a_sidx_reg >= dom_a.points;
        else
            b_ctl_next.err = (a_op_reg > OP_AT_INDEX) || (a_mode_reg == MODE_BAD)
                             || (dom_a.points == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_ctl_reg  <= b_ctl_next;
            b_mode_reg <= a_mode_reg;
            b_diff_reg <= diff_w[VAL_W-1:0];
        end
    end

    // divider operands: floor diff/step, ceil (diff+step-1)/step,
    // nearest ties down (2*diff+step-1)/(2*step)
    dom_t              dom_b;
    logic              near;
    logic [VAL_W:0]    num_base;
    logic [STEP_W-1:0] num_add;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;

    assign dom_b    = b_ctl_reg.dsel ? dom1_reg : dom0_reg;
    assign near     = b_mode_reg == MODE_NEAR;
    assign num_base = near ? {b_diff_reg, 1'b0} : {1'b0, b_diff_reg};
    assign num_add  = (b_mode_reg == MODE_FLOOR) ? '0 : dom_b.step - STEP_W'(1);
    assign div_num  = NUM_W'(num_base) + NUM_W'(num_add);
    assign div_den  = near ? {dom_b.step, 1'b0} : {1'b0, dom_b.step};

    logic [QUO_W-1:0] div_quo;
    ctl_t             div_ctl;

    udq_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_v_reg),
        .in_ready  (div_in_ready),
        .in_num    (div_num),
        .in_den    (div_den),
        .in_ctl    (b_ctl_reg),
        .out_valid (div_v),
        .out_ready (en_c),
        .out_quo   (div_quo),
        .out_ctl   (div_ctl)
    );

    // ---------------- C: index clamp ----------------
    dom_t             dom_q;
    logic [IDX_W-1:0] pts_m1;
    post_t            c_next;
    post_t            c_reg;

    assign dom_q  = div_ctl.dsel ? dom1_reg : dom0_reg;
    assign pts_m1 = dom_q.points - IDX_W'(1);

    always_comb
    begin
        c_next.ctl = div_ctl;
        if (div_ctl.op == OP_AT_INDEX)
            c_next.k = div_ctl.sidx;
        else if (div_ctl.lo)
            c_next.k = '0;
        else if (div_ctl.hi)
            c_next.k = pts_m1;
        else if (div_ctl.zstep)
            c_next.k = '0;
        else if (div_quo > QUO_W'(pts_m1))
            c_next.k = pts_m1;
        else
            c_next.k = div_quo[IDX_W-1:0];
        c_next.first = c_next.k == '0;
        c_next.last  = c_next.k == pts_m1;
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
            c_reg <= c_next;
    end

    // ---------------- D: step * index ----------------
    dom_t          dom_c;
    post_t         d_reg;
    logic [MW-1:0] d_m_reg;

    assign dom_c = c_reg.ctl.dsel ? dom1_reg : dom0_reg;

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            d_reg   <= c_reg;
            d_m_reg <= MW'(dom_c.step) * MW'(c_reg.k);
        end
    end

    // ---------------- E: low + step * index ----------------
    dom_t                 dom_d;
    post_t                e_reg;
    logic signed [SW-1:0] e_s_reg;

    assign dom_d = d_reg.ctl.dsel ? dom1_reg : dom0_reg;

    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            e_reg   <= d_reg;
            e_s_reg <= {{(SW-VAL_W){dom_d.low[VAL_W-1]}}, dom_d.low}
                       + {{(SW-MW){1'b0}}, d_m_reg};
        end
    end

    // ---------------- F: neighbor point and saturation ----------------
    dom_t                    dom_e;
    logic                    nb_down;
    logic [SW-1:0]           step_x;
    logic signed [SW-1:0]    nb_s;
    post_t                   f_reg;
    logic signed [VAL_W-1:0] f_pv_reg;
    logic signed [VAL_W-1:0] f_nv_reg;

    assign dom_e   = e_reg.ctl.dsel ? dom1_reg : dom0_reg;
    assign nb_down = e_reg.ctl.op inside {OP_NEXT_LO, OP_EQ_LO};
    assign step_x  = {{(SW-STEP_W){1'b0}}, dom_e.step};
    assign nb_s    = nb_down ? e_s_reg - step_x : e_s_reg + step_x;

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            f_reg    <= e_reg;
            f_pv_reg <= sat_val(e_s_reg);
            f_nv_reg <= sat_val(nb_s);
        end
    end

    // ---------------- G: result select, output register ----------------
    dom_t                    dom_f;
    logic signed [VAL_W-1:0] rv;
    logic [IDX_W-1:0]        ri;
    logic                    st;
    logic signed [VAL_W-1:0] g_value_reg;
    logic [IDX_W-1:0]        g_index_reg;
    logic                    g_status_reg;

    assign dom_f = f_reg.ctl.dsel ? dom1_reg : dom0_reg;

    always_comb
    begin
        rv = f_reg.ctl.val;
        ri = '0;
        st = 1'b0;
        if (f_reg.ctl.op == OP_AT_INDEX)
        begin
            ri = f_reg.ctl.sidx;
            if (f_reg.ctl.err)
            begin
                rv = '0;
                st = 1'b1;
            end
            else
                rv = f_pv_reg;
        end
        else if (f_reg.ctl.err)
            st = 1'b1;
        else
        begin
            ri = f_reg.k;
            case (f_reg.ctl.op)
                OP_INDEX, OP_SNAP:
                    rv = f_pv_reg;
                OP_NEXT_LO, OP_EQ_LO:
                begin
                    if (f_reg.ctl.op == OP_EQ_LO && f_pv_reg == f_reg.ctl.val)
                        rv = f_reg.ctl.val;
                    else if (f_reg.first)
                        rv = f_reg.ctl.wrap ? dom_f.high : f_reg.ctl.val;
                    else
                        rv = f_nv_reg;
                end
                OP_NEXT_HI, OP_EQ_HI:
                begin
                    if (f_reg.ctl.op == OP_EQ_HI && f_pv_reg == f_reg.ctl.val)
                        rv = f_reg.ctl.val;
                    else if (f_reg.last)
                        rv = f_reg.ctl.wrap ? dom_f.low : f_reg.ctl.val;
                    else
                        rv = f_nv_reg;
                end
                default:
                    rv = f_reg.ctl.val;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_g)
        begin
            g_value_reg  <= rv;
            g_index_reg  <= ri;
            g_status_reg <= st;
        end
    end

    assign m_axis_tvalid = g_v_reg;
    assign m_axis_tdata  = M_DATA_W'({g_index_reg, g_value_reg});
    assign m_axis_tuser  = M_USER_W'(g_status_reg);

endmodule

### hw/rtl/udq_checker.sv
// Port-level checks of the uniform domain quantizer and their bind.
module udq_checker
    import udq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [ADDR_W-1:0]   paddr,
    input logic [DATA_W-1:0]   pwdata,
    input logic [DATA_W-1:0]   prdata,
    input logic                pready,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic [M_USER_W-1:0] m_axis_tuser
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // input only stalls when the whole pipe is full and the output is blocked
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with room in the pipe");

    // no output beat straight out of reset
    a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // written domain low reads back
    a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_D0_LOW |=>
            paddr[ADDR_W-1:2] != REG_D0_LOW || prdata == $past(pwdata))
        else $error("register readback mismatch");

endmodule

bind uniform_domain_quantizer udq_checker u_udq_checker (.*);

### bench/tb.sv
// Testbench for the uniform domain quantizer: directed and random queries against a predictor.
`timescale 1ns / 1ps

module tb;
    import udq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;
    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -VAL_MAX - 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_QUERIES = 240;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic                    dsel;
        logic signed [VAL_W-1:0] val;
        logic [MODE_W-1:0]       mode;
        logic                    wrap;
        logic [IDX_W-1:0]        sidx;
    } query_t;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             status;
    } answer_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // value[31:0], snap_mode[33:32], wrap[34], step_index[50:35], zero fill
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    // operation[2:0], domain_select[3]
    logic [S_USER_W-1:0] s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // result_value[31:0], result_index[47:32]
    logic [M_DATA_W-1:0] m_axis_tdata;
    // status[0]
    logic [M_USER_W-1:0] m_axis_tuser;

    dom_t    shadow [2];
    answer_t due_results [$];
    bit      no_idle = 1'b0;
    int      mismatches = 0;
    int      queries_sent = 0;
    int      results_checked = 0;
    int      reg_writes = 0;
    int      idle_cycles = 0;

    uniform_domain_quantizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [VAL_W-1:0] clip_val(longint x);
        if (x > VAL_MAX)
            return VAL_MAX[VAL_W-1:0];
        if (x < VAL_MIN)
            return VAL_MIN[VAL_W-1:0];
        return x[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] grid_point(dom_t dm, longint k);
        return clip_val(longint'($signed(dm.low)) + longint'(dm.step) * k);
    endfunction

    function automatic longint grid_index(dom_t dm, longint v, logic [MODE_W-1:0] mode);
        longint lo, hi, st, last, diff, q;
        lo = longint'($signed(dm.low));
        hi = longint'($signed(dm.high));
        st = longint'(dm.step);
        last = longint'(dm.points) - 1;
        if (v <= lo)
            return 0;
        if (v >= hi)
            return last;
        if (st == 0)
            return 0;
        diff = v - lo;
        if (mode == MODE_FLOOR)
            q = diff / st;
        else if (mode == MODE_CEIL)
            q = (diff + st - 1) / st;
        else if (2 * diff <= st)
            q = 0;
        else
            q = (2 * diff + st - 1) / (2 * st);
        if (q > last)
            q = last;
        return q;
    endfunction

    function automatic answer_t quantize(query_t q);
        dom_t             dm;
        longint           k, pts;
        logic [VAL_W-1:0] pv;
        answer_t          a;
        dm = shadow[q.dsel];
        pts = longint'(dm.points);
        a.value = q.val;
        a.index = '0;
        a.status = 1'b0;
        if (q.op == OP_AT_INDEX)
        begin
            a.index = q.sidx;
            if (longint'(q.sidx) < pts)
                a.value = grid_point(dm, longint'(q.sidx));
            else
            begin
                a.value = '0;
                a.status = 1'b1;
            end
        end
        else if (q.op == OP_UNDEFINED || q.mode == MODE_BAD || pts == 0)
            a.status = 1'b1;
        else
        begin
            k = grid_index(dm, longint'(q.val), q.mode);
            a.index = k[IDX_W-1:0];
            pv = grid_point(dm, k);
            case (q.op)
                OP_INDEX, OP_SNAP:
                    a.value = pv;
                OP_NEXT_LO, OP_EQ_LO:
                    if (q.op == OP_EQ_LO && pv == q.val)
                        a.value = q.val;
                    else if (k == 0)
                        a.value = q.wrap ? dm.high : q.val;
                    else
                        a.value = grid_point(dm, k - 1);
                default:
                    if (q.op == OP_EQ_HI && pv == q.val)
                        a.value = q.val;
                    else if (k + 1 >= pts)
                        a.value = q.wrap ? dm.low : q.val;
                    else
                        a.value = grid_point(dm, k + 1);
            endcase
        end
        return a;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_D0_LOW:  shadow[0].low = data;
            REG_D0_HIGH: shadow[0].high = data;
            REG_D0_STEP: shadow[0].step = data[STEP_W-1:0];
            REG_D0_PTS:  shadow[0].points = data[IDX_W-1:0];
            REG_D1_LOW:  shadow[1].low = data;
            REG_D1_HIGH: shadow[1].high = data;
            REG_D1_STEP: shadow[1].step = data[STEP_W-1:0];
            default:     shadow[1].points = data[IDX_W-1:0];
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_domain(input logic d, input logic [VAL_W-1:0] lo,
                              input logic [VAL_W-1:0] hi, input logic [STEP_W-1:0] st,
                              input logic [IDX_W-1:0] pts);
        write_reg(d ? REG_D1_LOW : REG_D0_LOW, lo);
        write_reg(d ? REG_D1_HIGH : REG_D0_HIGH, hi);
        write_reg(d ? REG_D1_STEP : REG_D0_STEP, DATA_W'(st));
        write_reg(d ? REG_D1_PTS : REG_D0_PTS, DATA_W'(pts));
    endtask

    task automatic send_query(input query_t q);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= S_DATA_W'({q.sidx, q.wrap, q.mode, q.val});
        s_axis_tuser <= {q.dsel, q.op};
        do @(posedge clk); while (!s_axis_tready);
        due_results.insert(due_results.size(), quantize(q));
        queries_sent++;
    endtask

    task automatic ask(input logic [OP_W-1:0] op, input logic dsel, input logic [VAL_W-1:0] val,
                       input logic [MODE_W-1:0] mode, input logic wrap,
                       input logic [IDX_W-1:0] sidx);
        query_t q;
        q.op = op;
        q.dsel = dsel;
        q.val = val;
        q.mode = mode;
        q.wrap = wrap;
        q.sidx = sidx;
        send_query(q);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value(dom_t dm);
        longint lo, hi, st, k, off, v;
        lo = longint'($signed(dm.low));
        hi = longint'($signed(dm.high));
        st = longint'(dm.step);
        case ($urandom_range(0, 9))
            0: v = longint'($signed($urandom()));
            1:
                case ($urandom_range(0, 3))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = 0;
                    default: v = -1;
                endcase
            2: v = lo + longint'($urandom_range(0, 4)) - 2;
            3: v = hi + longint'($urandom_range(0, 4)) - 2;
            default:
            begin
                k = longint'($urandom_range(0, dm.points + 1));
                case ($urandom_range(0, 5))
                    0: off = -1;
                    1: off = 0;
                    2: off = 1;
                    3: off = st / 2;
                    4: off = st / 2 + 1;
                    default: off = longint'($urandom_range(0, st));
                endcase
                v = lo + st * k + off;
            end
        endcase
        return v[VAL_W-1:0];
    endfunction

    task automatic pick_domain(input logic d);
        longint lo, hi, st, pts;
        case ($urandom_range(0, 7))
            0:
            begin
                lo = longint'($signed($urandom()));
                hi = longint'($signed($urandom()));
                st = longint'($urandom() & 32'h7FFF_FFFF);
                pts = 0;
            end
            1:
            begin
                lo = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
                st = longint'($urandom_range(1, 1 << 18));
                pts = longint'($urandom_range(1, 20));
                hi = lo + st * (pts - 1);
                if ($urandom_range(0, 3) == 0)
                    hi = hi + longint'($urandom_range(0, st));
            end
            2:
            begin
                lo = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
                hi = lo + longint'($urandom_range(0, 1 << 18));
                st = 0;
                pts = longint'($urandom_range(1, 5));
            end
            3:
            begin
                lo = VAL_MIN;
                hi = VAL_MAX;
                st = VAL_MAX;
                pts = 65535;
            end
            4:
            begin
                lo = longint'($signed($urandom()));
                hi = longint'($signed($urandom()));
                st = longint'($urandom() & 32'h7FFF_FFFF);
                pts = longint'($urandom() & 32'hFFFF);
            end
            5:
            begin
                lo = longint'($urandom_range(0, 1 << 20));
                hi = lo - longint'($urandom_range(1, 1 << 20));
                st = longint'($urandom_range(1, 1 << 16));
                pts = longint'($urandom_range(1, 10));
            end
            6:
            begin
                lo = longint'($signed($urandom()));
                st = 1;
                pts = 65535;
                hi = lo + 65534;
            end
            default:
            begin
                lo = (1 << 30) + longint'($urandom_range(0, 1 << 16));
                st = 1 << 28;
                pts = 16;
                hi = VAL_MAX;
            end
        endcase
        set_domain(d, lo[VAL_W-1:0], hi[VAL_W-1:0], st[STEP_W-1:0], pts[IDX_W-1:0]);
    endtask

    // Registers still at reset: both domains absent.
    task automatic test_absent_domains();
        ask(OP_INDEX, 1'b0, 32'h0000_0000, MODE_FLOOR, 1'b0, 16'h0000);
        ask(OP_NEXT_HI, 1'b1, 32'h7FFF_FFFF, MODE_NEAR, 1'b1, 16'hFFFF);
        ask(OP_AT_INDEX, 1'b0, 32'h8000_0000, MODE_BAD, 1'b0, 16'h0000);
        ask(OP_UNDEFINED, 1'b1, 32'hFFFF_FFFF, MODE_CEIL, 1'b1, 16'h5A5A);
        drain_results();
    endtask

    // d0: -10.0 .. 10.0 step 2.5, nine points; d1: full range, saturating points.
    task automatic test_fixed_grids();
        set_domain(1'b0, -655360, 655360, 31'd163840, 16'd9);
        set_domain(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
        ask(OP_INDEX, 1'b0, 196608, MODE_FLOOR, 1'b0, 16'd0);
        ask(OP_INDEX, 1'b0, 196608, MODE_CEIL, 1'b0, 16'd0);
        ask(OP_SNAP, 1'b0, 196608, MODE_NEAR, 1'b0, 16'd0);
        // exact half step: tie goes down
        ask(OP_SNAP, 1'b0, -573440, MODE_NEAR, 1'b0, 16'd0);
        ask(OP_SNAP, 1'b0, -573439, MODE_NEAR, 1'b0, 16'd0);
        // ends: wrap to opposite bound or hold the input
        ask(OP_NEXT_LO, 1'b0, -655360, MODE_FLOOR, 1'b1, 16'd0);
        ask(OP_NEXT_LO, 1'b0, 32'h8000_0000, MODE_CEIL, 1'b0, 16'd0);
        ask(OP_NEXT_HI, 1'b0, 32'h7FFF_FFFF, MODE_FLOOR, 1'b1, 16'd0);
        ask(OP_NEXT_HI, 1'b0, 655360, MODE_NEAR, 1'b0, 16'd0);
        ask(OP_NEXT_LO, 1'b0, 196608, MODE_FLOOR, 1'b0, 16'd0);
        ask(OP_NEXT_HI, 1'b0, 196608, MODE_FLOOR, 1'b0, 16'd0);
        // on a point exactly
        ask(OP_EQ_LO, 1'b0, 327680, MODE_FLOOR, 1'b0, 16'd0);
        ask(OP_EQ_HI, 1'b0, 327680, MODE_CEIL, 1'b0, 16'd0);
        ask(OP_EQ_LO, 1'b0, 196608, MODE_CEIL, 1'b0, 16'd0);
        ask(OP_EQ_HI, 1'b0, 196608, MODE_FLOOR, 1'b0, 16'd0);
        ask(OP_INDEX, 1'b0, 196608, MODE_BAD, 1'b0, 16'd0);
        ask(OP_UNDEFINED, 1'b0, 196608, MODE_FLOOR, 1'b0, 16'd0);
        ask(OP_AT_INDEX, 1'b0, 0, MODE_BAD, 1'b0, 16'd8);
        ask(OP_AT_INDEX, 1'b0, 0, MODE_FLOOR, 1'b0, 16'd9);
        ask(OP_AT_INDEX, 1'b1, 0, MODE_FLOOR, 1'b0, 16'hFFFE);
        ask(OP_AT_INDEX, 1'b1, 0, MODE_FLOOR, 1'b0, 16'hFFFF);
        ask(OP_INDEX, 1'b1, 0, MODE_NEAR, 1'b0, 16'd0);
        ask(OP_NEXT_HI, 1'b1, 0, MODE_CEIL, 1'b1, 16'd0);
        ask(OP_SNAP, 1'b1, 32'h7FFF_FFFE, MODE_FLOOR, 1'b0, 16'd0);
        drain_results();
    endtask

    task automatic test_zero_step();
        set_domain(1'b1, -65536, 65536, 31'd0, 16'd5);
        ask(OP_NEXT_HI, 1'b1, 0, MODE_NEAR, 1'b0, 16'd0);
        ask(OP_INDEX, 1'b1, 65536, MODE_CEIL, 1'b0, 16'd0);
        drain_results();
    endtask

    task automatic test_random_grids();
        query_t q;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pick_domain(1'b0);
            pick_domain(1'b1);
            for (int i = 0; i < PHASE_QUERIES; i++)
            begin
                if (i % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                q.dsel = 1'($urandom_range(0, 1));
                q.op = ($urandom_range(0, 15) == 0) ? OP_UNDEFINED : OP_W'($urandom_range(0, 6));
                q.mode = ($urandom_range(0, 9) == 0) ? MODE_BAD : MODE_W'($urandom_range(0, 2));
                q.wrap = 1'($urandom_range(0, 1));
                q.val = pick_value(shadow[q.dsel]);
                if ($urandom_range(0, 3) == 0)
                    q.sidx = IDX_W'($urandom());
                else
                    q.sidx = IDX_W'($urandom_range(0, shadow[q.dsel].points + 1));
                send_query(q);
            end
            drain_results();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        for (int d = 0; d < 2; d++)
            shadow[d] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_absent_domains();
        test_fixed_grids();
        test_zero_step();
        test_random_grids();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("tb: %0d queries sent, %0d results checked, %0d register writes",
                 queries_sent, results_checked, reg_writes);
        $display("tb: absent, fixed, zero-step and %0d random grid pairs covered",
                 RANDOM_PHASES);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // result side backpressure, one stall draw per beat
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_results
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat, value %h index %h status %b", $time,
                         m_axis_tdata[VAL_W-1:0], m_axis_tdata[VAL_W+IDX_W-1:VAL_W],
                         m_axis_tuser[0]);
            end
            else
            begin
                want = due_results.pop_front();
                if (want.value !== m_axis_tdata[VAL_W-1:0] ||
                    want.index !== m_axis_tdata[VAL_W+IDX_W-1:VAL_W] ||
                    want.status !== m_axis_tuser[0])
                begin
                    mismatches++;
                    if (want.value !== m_axis_tdata[VAL_W-1:0])
                        $display("%0t: result_value expected %h got %h", $time,
                                 want.value, m_axis_tdata[VAL_W-1:0]);
                    if (want.index !== m_axis_tdata[VAL_W+IDX_W-1:VAL_W])
                        $display("%0t: result_index expected %h got %h", $time,
                                 want.index, m_axis_tdata[VAL_W+IDX_W-1:VAL_W]);
                    if (want.status !== m_axis_tuser[0])
                        $display("%0t: status expected %b got %b", $time,
                                 want.status, m_axis_tuser[0]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule

### sim.f
hw/rtl/udq_pkg.sv
hw/rtl/udq_divider.sv
hw/rtl/uniform_domain_quantizer.sv
hw/rtl/udq_checker.sv
bench/tb.sv
